// File: hdl/assert_macros.svh
// assertion macros for the checker file
// clocked on clk, one of them switched off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only out of reset
`define FAC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define FAC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/fac_pkg.sv
// shared types and constants of the feedforward audio compressor
// used by the register file, the controller, the datapath and the top level
package fac_pkg;

	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 3;

	// register indexes on the configuration channel
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_ENABLE    = 3'd0,
		REG_ATTACK    = 3'd1,
		REG_RELEASE   = 3'd2,
		REG_AMOUNT    = 3'd3,
		REG_THRESHOLD = 3'd4
	} cfg_reg_t;

	// reset values at full width, cut down to the register widths on use
	localparam logic [CFG_DATA_BITS-1:0] ATTACK_RST    = 32'd65263;
	localparam logic [CFG_DATA_BITS-1:0] RELEASE_RST   = 32'd65526;
	localparam logic [CFG_DATA_BITS-1:0] THRESHOLD_RST = 32'd1845494;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PASS,
		ST_MUL_ENV,
		ST_MUL_NEW,
		ST_ENV,
		ST_MUL_OVER,
		ST_DEN,
		ST_DIV,
		ST_MUL_GAIN,
		ST_ROUND,
		ST_MUL_MK,
		ST_FIN,
		ST_DONE
	} state_t;

	// operand pairs of the shared multiplier
	typedef enum logic [2:0] {
		MUL_C_ENV,
		MUL_INVC_MAG,
		MUL_AMT_MAKEUP,
		MUL_AMT_OVER,
		MUL_MAG_GAIN,
		MUL_Y_MK
	} mul_sel_t;

	typedef struct packed {
		logic     capture;
		logic     pass_load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     env_load;
		logic     mk_load;
		logic     den_load;
		logic     gain_unity;
		logic     div_step;
		logic     y_load;
		logic     fin_load;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic enable;
		logic over;
		logic out_free;
	} dp_status_t;

endpackage

// File: hdl/fac_cfg_regs.sv
// configuration register file of the compressor
// depends on fac_pkg for register indexes and reset values
module fac_cfg_regs import fac_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                      comp_enable,
	output logic [COEF_BITS-1:0]      attack_coef,
	output logic [COEF_BITS-1:0]      release_coef,
	output logic [COEF_BITS:0]        comp_amount,
	output logic [SAMPLE_BITS-2:0]    threshold_level
);

	logic                   enable_q;
	logic [COEF_BITS-1:0]   attack_q;
	logic [COEF_BITS-1:0]   release_q;
	logic [COEF_BITS:0]     amount_q;
	logic [SAMPLE_BITS-2:0] threshold_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			attack_q    <= ATTACK_RST[COEF_BITS-1:0];
			release_q   <= RELEASE_RST[COEF_BITS-1:0];
			amount_q    <= '0;
			threshold_q <= THRESHOLD_RST[SAMPLE_BITS-2:0];
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ENABLE:    enable_q    <= cfg_data[0];
				REG_ATTACK:    attack_q    <= cfg_data[COEF_BITS-1:0];
				REG_RELEASE:   release_q   <= cfg_data[COEF_BITS-1:0];
				REG_AMOUNT:    amount_q    <= cfg_data[COEF_BITS:0];
				REG_THRESHOLD: threshold_q <= cfg_data[SAMPLE_BITS-2:0];
				default: begin
				end
			endcase
		end
	end

	assign comp_enable     = enable_q;
	assign attack_coef     = attack_q;
	assign release_coef    = release_q;
	assign comp_amount     = amount_q;
	assign threshold_level = threshold_q;

endmodule

// File: hdl/fac_ctrl.sv
// sequencer of the compressor: walks one sample through the shared
// multiplier and the serial divider; depends on fac_pkg
module fac_ctrl import fac_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	localparam int CNT_W = $clog2(SAMPLE_BITS);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SAMPLE_BITS - 1);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DEN) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.enable ? ST_MUL_ENV : ST_PASS;
				end
			end
			ST_PASS:     state_d = ST_DONE;
			ST_MUL_ENV:  state_d = ST_MUL_NEW;
			ST_MUL_NEW:  state_d = ST_ENV;
			ST_ENV:      state_d = ST_MUL_OVER;
			ST_MUL_OVER: state_d = ST_DEN;
			ST_DEN:      state_d = status.over ? ST_DIV : ST_MUL_GAIN;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_MUL_GAIN;
				end
			end
			ST_MUL_GAIN: state_d = ST_ROUND;
			ST_ROUND:    state_d = ST_MUL_MK;
			ST_MUL_MK:   state_d = ST_FIN;
			ST_FIN:      state_d = ST_DONE;
			ST_DONE: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mul_sel = MUL_C_ENV;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_PASS: cmd.pass_load = 1'b1;
			ST_MUL_ENV: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_C_ENV;
			end
			ST_MUL_NEW: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_INVC_MAG;
				cmd.acc_load = 1'b1;
			end
			ST_ENV: begin
				cmd.env_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_AMT_MAKEUP;
			end
			ST_MUL_OVER: begin
				cmd.mk_load = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_AMT_OVER;
			end
			ST_DEN: begin
				cmd.den_load   = status.over;
				cmd.gain_unity = !status.over;
			end
			ST_DIV: cmd.div_step = 1'b1;
			ST_MUL_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_MAG_GAIN;
			end
			ST_ROUND: cmd.y_load = 1'b1;
			ST_MUL_MK: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_Y_MK;
			end
			ST_FIN:  cmd.fin_load = 1'b1;
			ST_DONE: cmd.out_load = status.out_free;
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/fac_datapath.sv
// datapath of the compressor: envelope, shared multiplier, restoring
// divider for the gain and the output register; depends on fac_pkg
module fac_datapath import fac_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dp_cmd_t                cmd,
	output dp_status_t             status,
	input  logic                   comp_enable,
	input  logic [COEF_BITS-1:0]   attack_coef,
	input  logic [COEF_BITS-1:0]   release_coef,
	input  logic [COEF_BITS:0]     comp_amount,
	input  logic [SAMPLE_BITS-2:0] threshold_level,
	input  logic [SAMPLE_BITS-1:0] sample_in,
	output logic [SAMPLE_BITS-1:0] sample_out,
	output logic                   clipped,
	output logic                   out_valid,
	input  logic                   out_ready
);

	localparam int S     = SAMPLE_BITS;
	localparam int C     = COEF_BITS;
	localparam int MW    = (S > C + 1) ? S : C + 1;
	localparam int ACC_W = S + C + 1;
	localparam int DEN_W = S + 3;
	localparam int FIV_W = S + C + 3;

	localparam logic [MW-1:0]    MAKEUP_OP = MW'((3 * (2 ** C) + 5) / 10);
	localparam logic [S:0]       HALF_W    = {2'b01, {(S - 1){1'b0}}};
	localparam logic [S-1:0]     HALF_S    = {1'b1, {(S - 1){1'b0}}};
	localparam logic [C:0]       ONE_C     = {1'b1, {C{1'b0}}};
	localparam logic [ACC_W-1:0] RND_ACC   = ACC_W'(1) << (C - 1);
	localparam logic [FIV_W-1:0] RND_FIV   = FIV_W'(1) << (C - 1);
	localparam logic [2*C:0]     RND_MK    = (2 * C + 1)'(1) << (C - 1);
	localparam logic [2*S-1:0]   RND_Y1    = (2 * S)'(1) << (S - 2);
	localparam logic [S+C:0]     RND_Y2    = (S + C + 1)'(1) << (C - 1);
	localparam logic [DEN_W-1:0] REM_BASE  = DEN_W'(1) << (S - 2);

	logic [S-1:0]     raw_q, mag_q, env_q, gain_q, y_q, res_q, out_data_q;
	logic             neg_q, clip_res_q, out_clip_q, out_valid_q;
	logic [2*MW-1:0]  prod_q;
	logic [ACC_W-1:0] acc_q;
	logic [C:0]       mk_q;
	logic [DEN_W-1:0] den_q, rem_q;
	logic [S-1:0]     num_q;

	logic [S-1:0]     mag_d, over;
	logic [C-1:0]     coef;
	logic [C:0]       inv_coef, amt;
	logic [MW-1:0]    op_a, op_b;
	logic [ACC_W-1:0] env_sum;
	logic [S:0]       env_rnd;
	logic [FIV_W-1:0] five_sum;
	logic [DEN_W-1:0] den_d, div_t;
	logic             div_ge;
	logic [2*C:0]     mk_sum;
	logic [2*S-1:0]   y1_sum;
	logic [S+C:0]     y2_sum;
	logic [S:0]       y2, y_sat;
	logic             clip_d;

	assign mag_d    = sample_in[S-1] ? (~sample_in + 1'b1) : sample_in;
	assign coef     = (mag_q > env_q) ? attack_coef : release_coef;
	assign inv_coef = ONE_C - {1'b0, coef};
	assign amt      = (comp_amount > ONE_C) ? ONE_C : comp_amount;
	assign over     = env_q - {1'b0, threshold_level};

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_C_ENV: begin
				op_a = MW'(env_q);
				op_b = MW'(coef);
			end
			MUL_INVC_MAG: begin
				op_a = MW'(mag_q);
				op_b = MW'(inv_coef);
			end
			MUL_AMT_MAKEUP: begin
				op_a = MAKEUP_OP;
				op_b = MW'(amt);
			end
			MUL_AMT_OVER: begin
				op_a = MW'(over);
				op_b = MW'(amt);
			end
			MUL_MAG_GAIN: begin
				op_a = MW'(mag_q);
				op_b = MW'(gain_q);
			end
			MUL_Y_MK: begin
				op_a = MW'(y_q);
				op_b = MW'(mk_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// envelope: rounded blend of old envelope and magnitude, held at full scale
	assign env_sum = acc_q + prod_q[ACC_W-1:0] + RND_ACC;
	assign env_rnd = env_sum[ACC_W-1:C];

	// denominator 1 + 5*amount*over, rounded into Q.23
	assign five_sum = (FIV_W'(prod_q[S+C-1:0]) << 2) + FIV_W'(prod_q[S+C-1:0]) + RND_FIV;
	assign den_d    = DEN_W'(HALF_S) + five_sum[FIV_W-1:C];

	// one quotient bit per step, numerator bits shifted in from num_q
	assign div_t  = {rem_q[DEN_W-2:0], num_q[S-1]};
	assign div_ge = div_t >= den_q;

	assign mk_sum = prod_q[2*C:0] + RND_MK;
	assign y1_sum = prod_q[2*S-1:0] + RND_Y1;
	assign y2_sum = prod_q[S+C:0] + RND_Y2;
	assign y2     = y2_sum[S+C:C];

	always_comb begin
		if (neg_q) begin
			clip_d = y2 > HALF_W;
			y_sat  = clip_d ? HALF_W : y2;
		end else begin
			clip_d = y2 >= HALF_W;
			y_sat  = clip_d ? (HALF_W - 1'b1) : y2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			raw_q <= sample_in;
			neg_q <= sample_in[S-1];
			mag_q <= mag_d;
		end
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q[ACC_W-1:0];
		end
		if (cmd.mk_load) begin
			mk_q <= ONE_C + mk_sum[2*C:C];
		end
		if (cmd.den_load) begin
			den_q <= den_d;
			rem_q <= REM_BASE + DEN_W'(den_d[DEN_W-2:S+1]);
			num_q <= den_d[S:1];
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? (div_t - den_q) : div_t;
			num_q <= {num_q[S-2:0], 1'b0};
		end
		if (cmd.gain_unity) begin
			gain_q <= HALF_S;
		end else if (cmd.div_step) begin
			gain_q <= {gain_q[S-2:0], div_ge};
		end
		if (cmd.y_load) begin
			y_q <= y1_sum[2*S-2:S-1];
		end
		if (cmd.fin_load) begin
			res_q      <= neg_q ? (~y_sat[S-1:0] + 1'b1) : y_sat[S-1:0];
			clip_res_q <= clip_d;
		end else if (cmd.pass_load) begin
			res_q      <= raw_q;
			clip_res_q <= 1'b0;
		end
		if (cmd.out_load) begin
			out_data_q <= res_q;
			out_clip_q <= clip_res_q;
		end
	end

	// envelope state and output valid are cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.env_load) begin
				env_q <= (env_rnd > HALF_W) ? HALF_S : env_rnd[S-1:0];
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.enable   = comp_enable;
	assign status.over     = env_q > {1'b0, threshold_level};
	assign status.out_free = !out_valid_q || out_ready;

	assign sample_out = out_data_q;
	assign clipped    = out_clip_q;
	assign out_valid  = out_valid_q;

endmodule

// File: hdl/feedforward_audio_compressor_unit.sv
// Feedforward audio compressor with a peak envelope follower.
// Input stream s_axis: one signed Q1.23 sample per word. Output stream
// m_axis: the compressed sample in tdata, the saturation flag in tuser.
// Configuration channel cfg_*: cfg_index picks the register (0 enable,
// 1 attack, 2 release, 3 amount, 4 threshold), cfg_data carries the value;
// cfg_ready is always high. The user must let writes go in only while the
// block is idle; the block itself does not enforce it.
// One sample is worked on at a time. With compression on and the envelope
// above the threshold, the result reaches the output register after six
// passes through one shared multiplier plus one quotient bit per cycle from
// the restoring divider that forms the gain. At or below the threshold the
// divider is skipped; with compression off the envelope holds. The sequencer
// is back in idle in the cycle after the result is loaded into the output
// register, and takes no new word before the result is loaded.
// s_axis_tready is high whenever the sequencer is idle, so a new sample is
// taken while the previous result still waits in the output register.
// If m_axis_tready stays low, the finished result is held in the datapath
// until the output register frees, and no further sample is taken.
// Reset clears the envelope, empties the output and loads the register
// defaults (compression off).
module feedforward_audio_compressor_unit import fac_pkg::*; #(
	parameter int SAMPLE_BITS = 24,
	parameter int COEF_BITS   = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // sample_in
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // sample_out
	output logic                                   m_axis_tuser,  // clipped
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]              cfg_index,
	input  logic [CFG_DATA_BITS-1:0]               cfg_data
);

	localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

	logic                   comp_enable;
	logic [COEF_BITS-1:0]   attack_coef;
	logic [COEF_BITS-1:0]   release_coef;
	logic [COEF_BITS:0]     comp_amount;
	logic [SAMPLE_BITS-2:0] threshold_level;
	logic [SAMPLE_BITS-1:0] sample_out;
	dp_cmd_t                cmd;
	dp_status_t             status;

	fac_cfg_regs #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_cfg (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.comp_enable    (comp_enable),
		.attack_coef    (attack_coef),
		.release_coef   (release_coef),
		.comp_amount    (comp_amount),
		.threshold_level(threshold_level)
	);

	fac_ctrl #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	fac_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.comp_enable    (comp_enable),
		.attack_coef    (attack_coef),
		.release_coef   (release_coef),
		.comp_amount    (comp_amount),
		.threshold_level(threshold_level),
		.sample_in      (s_axis_tdata[SAMPLE_BITS-1:0]),
		.sample_out     (sample_out),
		.clipped        (m_axis_tuser),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready)
	);

	assign m_axis_tdata = TDATA_BITS'(sample_out);

endmodule

// File: hdl/fac_checker.sv
// port-level checks of the compressor top level, attached by bind
// depends on assert_macros.svh
`include "assert_macros.svh"

module fac_checker #(
	parameter int SAMPLE_BITS = 24
) (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_axis_tvalid,
	input logic                                   s_axis_tready,
	input logic                                   m_axis_tvalid,
	input logic                                   m_axis_tready,
	input logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
	input logic                                   m_axis_tuser
);

	localparam logic [SAMPLE_BITS-1:0] POS_FULL = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] NEG_FULL = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

	// a stalled result word holds
	`FAC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed under stall")

	// no result while in reset
	`FAC_ASSERT_ALWAYS(a_rst_empty, !arst_n |-> !m_axis_tvalid, "output valid during reset")

	// one sample at a time: busy straight after an accepted word
	`FAC_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second word taken while busy")

	// a new result only comes out of a busy sequencer
	`FAC_ASSERT(a_rise_busy, $rose(m_axis_tvalid) |-> !$past(s_axis_tready), "result without a sample in work")

	// a clipped result sits at a full-scale value
	`FAC_ASSERT(a_clip_full, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[SAMPLE_BITS-1:0] == POS_FULL || m_axis_tdata[SAMPLE_BITS-1:0] == NEG_FULL, "clipped result not at full scale")

endmodule

bind feedforward_audio_compressor_unit fac_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_fac_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser)
);
